/* rtl/core/pubf_pkg.sv */
// pubf_pkg: shared types, sizes and helpers for the per-user byte fifo
// used by pubf_lookup and per_user_byte_fifo; no dependencies

package pubf_pkg;

   // sizing
   localparam int CHANNELS = 8;
   localparam int SLOTS    = 256;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W    = PTR_W + 1;
   localparam int ADDR_W   = (CHANNELS * SLOTS > 1) ? $clog2(CHANNELS * SLOTS) : 1;
   localparam int ID_W     = 32;
   localparam int BYTE_W   = 8;
   localparam int CAP_W    = 8;
   localparam int FILL_W   = 8;
   localparam int STAT_W   = 3;
   localparam int FUNC_W   = 2;
   localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;

   // request kinds
   typedef enum logic [FUNC_W-1:0] {
      FUNC_OPEN  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_CLOSE = 2'd3
   } func_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_EMPTY      = 3'd1,
      STAT_FULL       = 3'd2,
      STAT_EOS        = 3'd3,
      STAT_UNKNOWN    = 3'd4,
      STAT_TABLE_FULL = 3'd5
   } status_type;

   // control sequencer
   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_READ = 1'b1
   } state_type;

   // owner lookup result
   typedef struct packed {
      logic            hit;
      logic [CH_W-1:0] hit_idx;
      logic            free;
      logic [CH_W-1:0] free_idx;
   } lookup_type;

   // step a ring pointer, wrapping at the ring size
   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr,
                                                    input logic [CNT_W-1:0] ring);
      logic [CNT_W-1:0] sum;
      sum = {1'b0, ptr} + CNT_W'(1);
      return (sum >= ring) ? '0 : sum[PTR_W-1:0];
   endfunction

   // bytes held between read and write pointers
   function automatic logic [CNT_W-1:0] ring_fill(input logic [PTR_W-1:0] rd,
                                                  input logic [PTR_W-1:0] wr,
                                                  input logic [CNT_W-1:0] ring);
      logic [CNT_W-1:0] rd_x;
      logic [CNT_W-1:0] wr_x;
      rd_x = {1'b0, rd};
      wr_x = {1'b0, wr};
      return (wr_x >= rd_x) ? (wr_x - rd_x) : (wr_x + ring - rd_x);
   endfunction

endpackage

/* rtl/core/per_user_byte_fifo.sv */
// per_user_byte_fifo: multi-channel byte fifo, one ring per user id
// timing: result registered in the cycle after the item is taken; a read that
//   returns a byte passes the store read register and then the response register
// throughput: one item per cycle while no response stalls and no byte read is busy
// reset: channels freed, pointers and end flags cleared, capacity 255; the
//   byte store is not cleared, a slot is only read after it is written
// depends on pubf_pkg, pubf_lookup, pubf_ram

module per_user_byte_fifo import pubf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] user_id, [39:32] write_data
   input  logic [2:0]  req_tuser,   // [1:0] func, [2] writer_mode
   input  logic        req_tlast,   // last_in_request
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] read_data, [15:8] fill_level
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast,   // request_end
   // capacity register
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   // request fields
   logic [ID_W-1:0]   req_user_id;
   logic [BYTE_W-1:0] req_write_data;
   func_type          req_func;
   logic              req_writer;

   assign req_user_id    = req_tdata[ID_W-1:0];
   assign req_write_data = req_tdata[ID_W+BYTE_W-1:ID_W];
   assign req_func       = func_type'(req_tuser[FUNC_W-1:0]);
   assign req_writer     = req_tuser[FUNC_W];

   // channel table and control state
   state_type                     state_ff, state_in;
   logic [CAP_W-1:0]              cap_ff, cap_in;
   logic [CHANNELS-1:0]           valid_ff, valid_in;
   logic [CHANNELS-1:0][ID_W-1:0] owner_ff, owner_in;
   logic [CHANNELS-1:0]           eos_ff, eos_in;
   logic [PTR_W-1:0]              rd_ptr_ff [CHANNELS];
   logic [PTR_W-1:0]              rd_ptr_in [CHANNELS];
   logic [PTR_W-1:0]              wr_ptr_ff [CHANNELS];
   logic [PTR_W-1:0]              wr_ptr_in [CHANNELS];

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [FILL_W-1:0] rsp_fill_ff, rsp_fill_in;
   logic              rsp_last_ff, rsp_last_in;

   // byte store ports
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   // datapath helpers
   lookup_type        lookup;
   logic [CH_W-1:0]   sel;
   logic [CNT_W-1:0]  cap_eff;
   logic [CNT_W-1:0]  ring;
   logic [PTR_W-1:0]  cur_rd;
   logic [PTR_W-1:0]  cur_wr;
   logic [PTR_W-1:0]  nxt_rd;
   logic [PTR_W-1:0]  nxt_wr;
   logic [PTR_W-1:0]  new_rd;
   logic [PTR_W-1:0]  new_wr;
   logic              accept;
   logic              out_free;

   pubf_lookup u_lookup (
      .valid   (valid_ff),
      .owner   (owner_ff),
      .user_id (req_user_id),
      .result  (lookup)
   );

   pubf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CHANNELS * SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (req_write_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // effective ring size from the capacity register
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (int'(cap_ff) > SLOTS - 1) begin
         cap_eff = CNT_W'(SLOTS - 1);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
      ring = cap_eff + CNT_W'(1);
   end

   // selected channel and its pointers
   assign sel      = lookup.hit ? lookup.hit_idx : lookup.free_idx;
   assign cur_rd   = rd_ptr_ff[sel];
   assign cur_wr   = wr_ptr_ff[sel];
   assign nxt_rd   = ptr_advance(cur_rd, ring);
   assign nxt_wr   = ptr_advance(cur_wr, ring);
   assign ram_addr = ADDR_W'(sel) * ADDR_W'(SLOTS)
                   + (lookup.hit ? (req_func == FUNC_WRITE ? ADDR_W'(cur_wr)
                                                           : ADDR_W'(cur_rd))
                                 : '0);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == STATE_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   // next state, table update and response load
   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      valid_in      = valid_ff;
      owner_in      = owner_ff;
      eos_in        = eos_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      new_rd        = cur_rd;
      new_wr        = cur_wr;

      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               rsp_status_in = STAT_OK;
               rsp_data_in   = '0;
               rsp_last_in   = req_tlast;
               rsp_valid_in  = 1'b1;
               if (req_func == FUNC_OPEN) begin
                  if (lookup.hit) begin
                     if (req_writer) begin
                        eos_in[sel] = 1'b0;
                     end
                  end else if (lookup.free) begin
                     // claim the lowest free channel
                     valid_in[sel]  = 1'b1;
                     owner_in[sel]  = req_user_id;
                     eos_in[sel]    = 1'b0;
                     rd_ptr_in[sel] = '0;
                     wr_ptr_in[sel] = '0;
                     new_rd         = '0;
                     new_wr         = '0;
                  end else begin
                     rsp_status_in = STAT_TABLE_FULL;
                  end
               end else if (!lookup.hit) begin
                  rsp_status_in = STAT_UNKNOWN;
               end else begin
                  unique case (req_func)
                     FUNC_WRITE: begin
                        if (nxt_wr == cur_rd) begin
                           rsp_status_in = STAT_FULL;
                        end else begin
                           ram_wr_en      = 1'b1;
                           wr_ptr_in[sel] = nxt_wr;
                           new_wr         = nxt_wr;
                        end
                     end
                     FUNC_READ: begin
                        if (cur_rd == cur_wr) begin
                           if (eos_ff[sel]) begin
                              eos_in[sel]   = 1'b0;
                              rsp_status_in = STAT_EOS;
                           end else begin
                              rsp_status_in = STAT_EMPTY;
                           end
                        end else begin
                           // byte comes back from the store next cycle
                           ram_rd_en      = 1'b1;
                           rd_ptr_in[sel] = nxt_rd;
                           new_rd         = nxt_rd;
                           rsp_valid_in   = 1'b0;
                           state_in       = STATE_READ;
                        end
                     end
                     FUNC_CLOSE: begin
                        if (req_writer) begin
                           eos_in[sel] = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (lookup.hit || (req_func == FUNC_OPEN && lookup.free)) begin
                  rsp_fill_in = FILL_W'(ring_fill(new_rd, new_wr, ring));
               end else begin
                  rsp_fill_in = '0;
               end
            end
         end
         STATE_READ: begin
            rsp_data_in  = ram_rd_data;
            rsp_valid_in = 1'b1;
            state_in     = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase

      // capacity write empties every ring
      if (csr_we) begin
         cap_in = csr_wdata;
         for (int c = 0; c < CHANNELS; c++) begin
            rd_ptr_in[c] = '0;
            wr_ptr_in[c] = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         cap_ff       <= CAP_RESET;
         valid_ff     <= '0;
         eos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            rd_ptr_ff[c] <= '0;
            wr_ptr_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         valid_ff     <= valid_in;
         eos_ff       <= eos_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      owner_ff      <= owner_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_fill_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/core/pubf_ram.sv */
// pubf_ram: generic single-clock ram, one write and one registered read port
// no dependencies

module pubf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/pubf_lookup.sv */
// pubf_lookup: parallel owner match and lowest free channel search
// depends on pubf_pkg

module pubf_lookup import pubf_pkg::*; (
   input  logic [CHANNELS-1:0]           valid,
   input  logic [CHANNELS-1:0][ID_W-1:0] owner,
   input  logic [ID_W-1:0]               user_id,
   output lookup_type                    result
);

   // scan from the top so the lowest channel wins
   always_comb begin
      result = '0;
      for (int c = CHANNELS - 1; c >= 0; c--) begin
         if (valid[c] && (owner[c] == user_id)) begin
            result.hit     = 1'b1;
            result.hit_idx = CH_W'(c);
         end
         if (!valid[c]) begin
            result.free     = 1'b1;
            result.free_idx = CH_W'(c);
         end
      end
   end

endmodule

/* tb/sv/per_user_byte_fifo_checker.sv */
// per_user_byte_fifo_checker: watches the request, response and capacity ports,
// predicts each response from its own channel table and compares field by field
// depends on pubf_pkg for sizes, request kinds and status codes
`timescale 1ns / 100ps

module per_user_byte_fifo_checker import pubf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] user_id, [39:32] write_data
   input  logic [2:0]  req_tuser,   // [1:0] func, [2] writer_mode
   input  logic        req_tlast,   // last_in_request
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] read_data, [15:8] fill_level
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        rsp_tlast,   // request_end
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        flush_check, // end of run: anything still queued is missing
   output int          error_count
);

   typedef struct packed {
      status_type  status;
      logic [7:0]  read_data;
      logic [7:0]  fill_level;
      logic        request_end;
   } fifo_rsp_type;

   // shadow copy of the channel table
   logic [CAP_W-1:0] capacity_q;
   logic             chan_used  [CHANNELS];
   logic [ID_W-1:0]  chan_owner [CHANNELS];
   logic [PTR_W-1:0] rd_ptr     [CHANNELS];
   logic [PTR_W-1:0] wr_ptr     [CHANNELS];
   logic             eos_flag   [CHANNELS];
   logic [7:0]       ring_mem   [CHANNELS][SLOTS];

   fifo_rsp_type expected_rsp_q[$];
   int           mismatches = 0;
   int           rsp_index  = 0;

   assign error_count = mismatches;

   task automatic report_mismatch(input string what, input int want, input int got);
      if (mismatches < 100)
         $display("%0t: response %0d: %s expected %0d got %0d", $time, rsp_index, what,
                  want, got);
      mismatches++;
   endtask

   // one request against the shadow table, returns the response it should give
   function automatic fifo_rsp_type apply_request(input func_type func,
                                                  input logic [ID_W-1:0] id,
                                                  input logic writer, input logic [7:0] data,
                                                  input logic last);
      fifo_rsp_type res;
      int           ring;
      int           ch;
      int           nxt;
      int           rd;
      int           wr;
      ring = (capacity_q == 0) ? 1 : int'(capacity_q);
      if (ring > SLOTS - 1)
         ring = SLOTS - 1;
      ring = ring + 1;
      res.status = STAT_OK;
      res.read_data = '0;
      res.fill_level = '0;
      res.request_end = last;
      ch = -1;
      for (int c = 0; c < CHANNELS; c++)
         if (ch < 0 && chan_used[c] && chan_owner[c] == id)
            ch = c;
      if (func == FUNC_OPEN) begin
         if (ch >= 0) begin
            if (writer)
               eos_flag[ch] = 1'b0;
         end else begin
            for (int c = 0; c < CHANNELS; c++)
               if (ch < 0 && !chan_used[c])
                  ch = c;
            if (ch < 0) begin
               res.status = STAT_TABLE_FULL;
            end else begin
               chan_used[ch]  = 1'b1;
               chan_owner[ch] = id;
               rd_ptr[ch]     = '0;
               wr_ptr[ch]     = '0;
               eos_flag[ch]   = 1'b0;
            end
         end
      end else if (ch < 0) begin
         res.status = STAT_UNKNOWN;
      end else if (func == FUNC_WRITE) begin
         nxt = int'(wr_ptr[ch]) + 1;
         if (nxt >= ring)
            nxt = 0;
         if (nxt == int'(rd_ptr[ch])) begin
            res.status = STAT_FULL;
         end else begin
            ring_mem[ch][wr_ptr[ch]] = data;
            wr_ptr[ch] = PTR_W'(nxt);
         end
      end else if (func == FUNC_READ) begin
         if (rd_ptr[ch] == wr_ptr[ch]) begin
            if (eos_flag[ch]) begin
               eos_flag[ch] = 1'b0;
               res.status = STAT_EOS;
            end else begin
               res.status = STAT_EMPTY;
            end
         end else begin
            res.read_data = ring_mem[ch][rd_ptr[ch]];
            nxt = int'(rd_ptr[ch]) + 1;
            rd_ptr[ch] = (nxt >= ring) ? '0 : PTR_W'(nxt);
         end
      end else begin
         // only a writer close marks end of stream
         if (writer)
            eos_flag[ch] = 1'b1;
      end
      if (ch >= 0) begin
         rd = int'(rd_ptr[ch]);
         wr = int'(wr_ptr[ch]);
         res.fill_level = 8'((wr >= rd) ? wr - rd : wr + ring - rd);
      end
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      fifo_rsp_type want;
      if (reset) begin
         capacity_q = CAP_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            chan_used[c] = 1'b0;
            chan_owner[c] = '0;
            rd_ptr[c] = '0;
            wr_ptr[c] = '0;
            eos_flag[c] = 1'b0;
         end
         expected_rsp_q.delete();
      end else begin
         // compare first: a response never belongs to an item taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("response with no item pending, status", -1, int'(rsp_tuser));
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", int'(want.status), int'(rsp_tuser));
               if (rsp_tdata[7:0] !== want.read_data)
                  report_mismatch("read_data", int'(want.read_data), int'(rsp_tdata[7:0]));
               if (rsp_tdata[15:8] !== want.fill_level)
                  report_mismatch("fill_level", int'(want.fill_level), int'(rsp_tdata[15:8]));
               if (rsp_tlast !== want.request_end)
                  report_mismatch("request_end", int'(want.request_end), int'(rsp_tlast));
            end
            rsp_index++;
         end
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(apply_request(func_type'(req_tuser[1:0]),
                                                   req_tdata[31:0], req_tuser[2],
                                                   req_tdata[39:32], req_tlast));
         // capacity write empties every ring, owners and end flags stay
         if (csr_we) begin
            capacity_q = csr_wdata;
            for (int c = 0; c < CHANNELS; c++) begin
               rd_ptr[c] = '0;
               wr_ptr[c] = '0;
            end
         end
         if (flush_check && expected_rsp_q.size() != 0) begin
            report_mismatch("responses never returned, count", 0, expected_rsp_q.size());
            expected_rsp_q.delete();
         end
      end
   end

endmodule

/* tb/sv/per_user_byte_fifo_test.sv */
// per_user_byte_fifo_test: drives directed and session-shaped random items into
// per_user_byte_fifo over several capacities; depends on pubf_pkg and the checker
`timescale 1ns / 100ps

module per_user_byte_fifo_test import pubf_pkg::*;;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;  // [31:0] user_id, [39:32] write_data
   logic [2:0]  req_tuser   = '0;  // [1:0] func, [2] writer_mode
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] read_data, [15:8] fill_level
   logic [2:0]  rsp_tuser;         // [2:0] status
   logic        rsp_tlast;
   logic        csr_we      = 1'b0;
   logic [7:0]  csr_wdata   = '0;
   logic        flush_check = 1'b0;
   int          error_count;

   int          send_gap_pct  = 12;
   int          rsp_stall_pct = 50;
   int          items_sent    = 0;
   int          results_seen  = 0;
   logic [7:0]  cap_setting   = CAP_RESET;
   logic [31:0] user_pool [10];

   per_user_byte_fifo DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   per_user_byte_fifo_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .flush_check (flush_check),
      .error_count (error_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver stalls at random
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         results_seen <= results_seen + 1;

   // hand one item over, with random gaps in front of it
   task automatic send_item(input func_type func, input logic [31:0] id, input logic writer,
                            input logic [7:0] data, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {data, id};
      req_tuser  <= {writer, func};
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      items_sent++;
   endtask

   // hold off until every response is back, then let the pipeline settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (results_seen < items_sent)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [7:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      cap_setting = value;
   endtask

   // mostly producer or consumer runs on one user, now and then a stray item
   task automatic run_session();
      logic [31:0] who;
      int          kind;
      int          room;
      int          n;
      who  = user_pool[$urandom_range(9)];
      room = (cap_setting == 0) ? 1 : int'(cap_setting);
      if (room > 12)
         room = 12;
      n    = $urandom_range(room + 2, 1);
      kind = $urandom_range(99);
      if (kind < 45) begin
         if ($urandom_range(1))
            send_item(FUNC_OPEN, who, 1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
         for (int i = 0; i < n; i++)
            send_item(FUNC_WRITE, who, 1'($urandom_range(1)), 8'($urandom_range(255)),
                      i == n - 1);
         if ($urandom_range(99) < 40)
            send_item(FUNC_CLOSE, who, 1'b1, 8'($urandom_range(255)), 1'b1);
      end else if (kind < 85) begin
         for (int i = 0; i < n; i++)
            send_item(FUNC_READ, who, 1'($urandom_range(1)), 8'($urandom_range(255)),
                      i == n - 1);
      end else begin
         if ($urandom_range(1))
            who = $urandom;
         send_item(func_type'($urandom_range(3)), who, 1'($urandom_range(1)),
                   8'($urandom_range(255)), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      logic       dup;
      logic [7:0] phase_cap [6];
      int         target;
      phase_cap = '{8'd1, 8'd3, 8'd0, 8'd255, 8'd5, 8'd2};

      // distinct user ids, superuser and all-ones among them
      user_pool[0] = 32'h0000_0000;
      user_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 10; i++) begin
         dup = 1'b1;
         while (dup) begin
            user_pool[i] = $urandom;
            dup = 1'b0;
            for (int j = 0; j < i; j++)
               if (user_pool[j] == user_pool[i])
                  dup = 1'b1;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unknown users, end of stream handling, table exhaustion
      send_item(FUNC_READ,  user_pool[0], 1'b0, 8'h00, 1'b0);
      send_item(FUNC_WRITE, user_pool[1], 1'b1, 8'hFF, 1'b1);
      send_item(FUNC_CLOSE, 32'h5A5A_A5A5, 1'b1, 8'h00, 1'b0);
      send_item(FUNC_OPEN,  user_pool[0], 1'b0, 8'h00, 1'b0);
      send_item(FUNC_READ,  user_pool[0], 1'b0, 8'h00, 1'b1);
      send_item(FUNC_WRITE, user_pool[0], 1'b1, 8'hFF, 1'b0);
      send_item(FUNC_WRITE, user_pool[0], 1'b0, 8'h00, 1'b1);
      send_item(FUNC_CLOSE, user_pool[0], 1'b1, 8'h00, 1'b0);
      // data ahead of end of stream comes out first
      send_item(FUNC_READ,  user_pool[0], 1'b0, 8'h00, 1'b0);
      send_item(FUNC_READ,  user_pool[0], 1'b0, 8'h00, 1'b0);
      send_item(FUNC_READ,  user_pool[0], 1'b0, 8'h00, 1'b0);
      send_item(FUNC_READ,  user_pool[0], 1'b0, 8'h00, 1'b1);
      // reader close changes nothing; writer reopen drops the end flag
      send_item(FUNC_CLOSE, user_pool[0], 1'b0, 8'h00, 1'b0);
      send_item(FUNC_CLOSE, user_pool[0], 1'b1, 8'h00, 1'b0);
      send_item(FUNC_OPEN,  user_pool[0], 1'b1, 8'h00, 1'b0);
      send_item(FUNC_READ,  user_pool[0], 1'b0, 8'h00, 1'b0);
      for (int i = 1; i < 9; i++)
         send_item(FUNC_OPEN, user_pool[i], i[0], 8'h00, 1'b0);
      send_item(FUNC_WRITE, user_pool[9], 1'b1, 8'h5A, 1'b1);
      // capacity zero behaves as one byte
      write_capacity(8'd0);
      send_item(FUNC_WRITE, user_pool[0], 1'b1, 8'hA5, 1'b0);
      send_item(FUNC_WRITE, user_pool[0], 1'b1, 8'h3C, 1'b1);
      send_item(FUNC_READ,  user_pool[0], 1'b0, 8'h00, 1'b1);

      // random phases over several capacities
      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 2) begin
            send_gap_pct  = 12;
            rsp_stall_pct = 50;
         end else if (ph < 4) begin
            send_gap_pct  = 50;
            rsp_stall_pct = 12;
         end else begin
            send_gap_pct  = 0;
            rsp_stall_pct = 0;
         end
         write_capacity(phase_cap[ph]);
         // at the largest capacity one ring is filled to the brim and past it
         if (phase_cap[ph] == 8'd255)
            for (int i = 0; i < 257; i++)
               send_item(FUNC_WRITE, user_pool[2], 1'($urandom_range(1)),
                         8'($urandom_range(255)), 1'($urandom_range(1)));
         target = items_sent + 70;
         while (items_sent < target)
            run_session();
      end

      wait_drained();
      repeat (4) @(posedge clock);
      flush_check <= 1'b1;
      @(posedge clock);
      flush_check <= 1'b0;
      @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
rtl/core/pubf_pkg.sv
rtl/core/pubf_ram.sv
rtl/core/pubf_lookup.sv
rtl/core/per_user_byte_fifo.sv
tb/sv/per_user_byte_fifo_checker.sv
tb/sv/per_user_byte_fifo_test.sv
